[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[rtl/irans_pkg.sv]
`timescale 1ns / 1ps

package irans_pkg;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_STATE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam int FREQ_W  = 13;
    localparam int CUMUL_W = 12;
    localparam int STATE_W = 32;
    localparam int SYM_W   = 8;
    localparam int LANE_W  = 5;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [SYM_W-1:0]   symbol;
        logic [FREQ_W-1:0]  freq_in;
        logic [CUMUL_W-1:0] cumul_in;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [STATE_W-1:0] out_data;
        logic [LANE_W-1:0]  lane;
        logic               last;
    } out_word_t;

    typedef struct packed {
        logic               start;
        logic [STATE_W-1:0] dividend;
        logic [FREQ_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [STATE_W-1:0] quotient;
        logic [FREQ_W-1:0]  remainder;
    } div_rsp_t;

endpackage

[rtl/irans_div.sv]
`timescale 1ns / 1ps

module irans_div
    import irans_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [STATE_W-1:0] quot_reg, quot_next;
    logic [FREQ_W:0]    rem_reg, rem_next;
    logic [FREQ_W-1:0]  dvs_reg, dvs_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [FREQ_W+1:0]  trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (req.start) begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'(STATE_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            trial = {rem_reg, quot_reg[STATE_W-1]} - {2'b00, dvs_reg};
            if (!trial[FREQ_W+1]) begin
                rem_next = trial[FREQ_W:0];
            end else begin
                rem_next = {rem_reg[FREQ_W-1:0], quot_reg[STATE_W-1]};
            end
            quot_next = {quot_reg[STATE_W-2:0], ~trial[FREQ_W+1]};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg[FREQ_W-1:0];

    `include "assert_macros.svh"
    `ASSERT_CLK(a_div_done_end, aclk, aresetn, done_reg |-> !busy_reg, "divider done while busy")
    `ASSERT_NEVER(a_div_restart, aclk, aresetn, busy_reg && req.start, "divider restarted while busy")
    `ASSERT_CLK(a_div_zero, aclk, aresetn, busy_reg |-> dvs_reg != '0, "divider given zero divisor")

endmodule

[rtl/interleaved_rans_encoder.sv]
`timescale 1ns / 1ps
// Interleaved rANS encoder with LANES byte-renormalised 32-bit states.
// The input channel (s_) takes words of opcode, symbol, freq_in and cumul_in.
// A load word writes the frequency and cumulative tables and gives no result.
// An encode word reads the tables and its lane state from block memories,
// emits renormalisation bytes low byte first, then divides the state by the
// frequency in a 32-step radix-2 divider and writes the lane back; if the
// frequency is zero it emits an error word instead and leaves the lane.
// A flush word emits every lane state as a word, lane 0 first, and resets
// each lane to the low state as it is emitted.
// One word is worked on at a time; results pass through a one-word output
// register, and a stalled receiver holds the encoder in its state when it
// has a word to emit or a division to start.
// After reset a clearing pass fills every lane with the low state before
// the first word is taken; the tables are not cleared.
module interleaved_rans_encoder
    import irans_pkg::*;
#(
    parameter int LANES      = 32,
    parameter int PROB_BITS  = 12,
    parameter int STATE_LOW  = 8388608,
    parameter int EMIT_POINT = 524288
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int LIDX_W = (LANES > 1) ? $clog2(LANES) : 1;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_READ  = 8'b0000_0100,
        ST_RENRM = 8'b0000_1000,
        ST_DIV   = 8'b0001_0000,
        ST_WB    = 8'b0010_0000,
        ST_FLUSH = 8'b0100_0000,
        ST_FRD   = 8'b1000_0000
    } state_t;

    logic [FREQ_W-1:0]  freq_mem  [256];
    logic [CUMUL_W-1:0] cumul_mem [256];
    logic [STATE_W-1:0] lane_mem  [LANES];

    state_t             st_reg, st_next;
    logic [LIDX_W-1:0]  cnt_reg, cnt_next;
    logic [LIDX_W-1:0]  idx_reg, idx_next;
    logic [LIDX_W-1:0]  lane_reg, lane_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic [STATE_W-1:0] x_reg, x_next;
    logic               emitted_reg, emitted_next;
    logic               ov_reg, ov_next;
    out_word_t          ow_reg, ow_next;

    logic [FREQ_W-1:0]  f_rd;
    logic [CUMUL_W-1:0] c_rd;
    logic [STATE_W-1:0] l_rd;
    logic [LIDX_W-1:0]  l_addr;
    logic               l_we;
    logic [STATE_W-1:0] l_wdata;
    logic [STATE_W-1:0] cur_x;
    logic [STATE_W+FREQ_W-1:0] limit;
    logic [63:0]        nx;
    div_req_t           dreq;
    div_rsp_t           drsp;
    logic               out_free;

    assign out_free = !ov_reg || m_ready;
    assign s_ready  = (st_reg == ST_IDLE) && out_free;
    assign m_valid  = ov_reg;
    assign m_data   = ow_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && s_data.opcode == OP_LOAD) begin
            freq_mem[s_data.symbol]  <= s_data.freq_in;
            cumul_mem[s_data.symbol] <= s_data.cumul_in;
        end
        f_rd <= freq_mem[sym_next];
        c_rd <= cumul_mem[sym_next];
        if (l_we) begin
            lane_mem[l_addr] <= l_wdata;
        end
        l_rd <= lane_mem[l_addr];
    end

    assign cur_x = (st_reg == ST_RENRM && emitted_reg) ? x_reg : l_rd;
    assign limit = (STATE_W+FREQ_W)'(EMIT_POINT) * {{STATE_W{1'b0}}, f_rd};
    assign nx = ({32'd0, drsp.quotient} << PROB_BITS) + 64'(c_rd) + 64'(drsp.remainder);

    irans_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    always_comb begin
        st_next      = st_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        lane_next    = lane_reg;
        sym_next     = sym_reg;
        x_next       = x_reg;
        emitted_next = emitted_reg;
        ov_next      = ov_reg;
        ow_next      = ow_reg;
        l_addr       = lane_reg;
        l_we         = 1'b0;
        l_wdata      = 32'(STATE_LOW);
        dreq         = '0;
        if (ov_reg && m_ready) begin
            ov_next = 1'b0;
        end
        case (st_reg)
            ST_CLEAR: begin
                l_addr = idx_reg;
                l_we   = 1'b1;
                idx_next = idx_reg + LIDX_W'(1);
                if (idx_reg == LIDX_W'(LANES - 1)) begin
                    idx_next = '0;
                    st_next  = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    sym_next = s_data.symbol;
                    if (s_data.opcode == OP_ENCODE) begin
                        lane_next = LIDX_W'(LANES - 1) - cnt_reg;
                        l_addr    = LIDX_W'(LANES - 1) - cnt_reg;
                        st_next   = ST_READ;
                    end else if (s_data.opcode == OP_FLUSH) begin
                        idx_next = '0;
                        l_addr   = '0;
                        st_next  = ST_FRD;
                    end
                end
            end
            ST_READ: begin
                emitted_next = 1'b0;
                if (out_free && f_rd == '0) begin
                    ov_next = 1'b1;
                    ow_next = '{kind: KIND_ERROR, out_data: '0,
                                lane: LANE_W'(lane_reg), last: 1'b1};
                    st_next = ST_IDLE;
                end else if (f_rd != '0) begin
                    st_next = ST_RENRM;
                end
            end
            ST_RENRM: begin
                if ({{FREQ_W{1'b0}}, cur_x} >= limit) begin
                    if (out_free) begin
                        ov_next = 1'b1;
                        ow_next = '{kind: KIND_BYTE, out_data: {24'd0, cur_x[7:0]},
                                    lane: LANE_W'(lane_reg),
                                    last: {{FREQ_W{1'b0}}, cur_x >> 8} < limit};
                        x_next  = cur_x >> 8;
                        emitted_next = 1'b1;
                    end
                end else if (out_free) begin
                    x_next  = cur_x;
                    dreq    = '{start: 1'b1, dividend: cur_x, divisor: f_rd};
                    st_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (drsp.done) begin
                    st_next = ST_WB;
                end
            end
            ST_WB: begin
                l_we     = 1'b1;
                l_wdata  = nx[31:0];
                cnt_next = (cnt_reg == LIDX_W'(LANES - 1)) ? '0 : cnt_reg + LIDX_W'(1);
                st_next  = ST_IDLE;
            end
            ST_FRD: begin
                l_addr  = idx_reg;
                st_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                l_addr = idx_reg;
                if (out_free) begin
                    ov_next = 1'b1;
                    ow_next = '{kind: KIND_STATE, out_data: l_rd, lane: LANE_W'(idx_reg),
                                last: idx_reg == LIDX_W'(LANES - 1)};
                    l_we = 1'b1;
                    if (idx_reg == LIDX_W'(LANES - 1)) begin
                        idx_next = '0;
                        cnt_next = '0;
                        st_next  = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + LIDX_W'(1);
                        l_addr   = idx_reg;
                        st_next  = ST_FRD;
                    end
                end
            end
            default: begin
                st_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_CLEAR;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            ov_reg      <= 1'b0;
            emitted_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            ov_reg      <= ov_next;
            emitted_reg <= emitted_next;
        end
        lane_reg <= lane_next;
        sym_reg  <= sym_next;
        x_reg    <= x_next;
        ow_reg   <= ow_next;
    end

    `include "assert_macros.svh"
    `ASSERT_CLK(a_ready_idle, aclk, aresetn, s_ready |-> st_reg == ST_IDLE, "ready outside idle")
    `ASSERT_CLK(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> $stable(m_data), "word changed")
    `ASSERT_CLK(a_wb_after_div, aclk, aresetn, st_reg == ST_WB |-> $past(drsp.done), "early writeback")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import irans_pkg::*;

    localparam int NLANES    = 32;
    localparam int PBITS     = 12;
    localparam int LOW_STATE = 8388608;
    localparam int EMIT_AT   = 524288;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    always #10 aclk = ~aclk;

    interleaved_rans_encoder DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    logic [FREQ_W-1:0]  freq_tab  [256];
    logic [CUMUL_W-1:0] cumul_tab [256];
    bit                 loaded    [256];
    logic [31:0]        lane_st   [NLANES];
    logic [4:0]         lane_cnt;
    byte unsigned       loaded_syms[$];

    out_word_t pending_words[$];
    int mismatches = 0;
    int words_sent = 0;
    int bytes_seen = 0;
    int states_seen = 0;
    int errors_seen = 0;
    int burst_left = 0;

    function automatic void clear_lanes();
        for (int i = 0; i < NLANES; i++) lane_st[i] = LOW_STATE;
        lane_cnt = '0;
    endfunction

    function automatic out_word_t mk_word(logic [1:0] k, logic [31:0] d, logic [4:0] ln,
                                          logic lst);
        out_word_t o;
        o.kind = k;
        o.out_data = d;
        o.lane = ln;
        o.last = lst;
        return o;
    endfunction

    function automatic void encode_model(in_word_t w);
        logic [4:0]  ln;
        logic [63:0] x;
        logic [63:0] f;
        logic [63:0] nx;
        int          first;
        out_word_t   o;
        case (w.opcode)
            OP_LOAD: begin
                freq_tab[w.symbol] = w.freq_in;
                cumul_tab[w.symbol] = w.cumul_in;
                if (!loaded[w.symbol]) loaded_syms.push_back(w.symbol);
                loaded[w.symbol] = 1'b1;
            end
            OP_ENCODE: begin
                ln = 5'(NLANES - 1) - lane_cnt;
                f = 64'(freq_tab[w.symbol]);
                if (f == 0) begin
                    pending_words.push_back(mk_word(KIND_ERROR, '0, ln, 1'b1));
                end else begin
                    x = 64'(lane_st[ln]);
                    first = pending_words.size();
                    while (x >= 64'(EMIT_AT) * f) begin
                        pending_words.push_back(mk_word(KIND_BYTE, {24'd0, x[7:0]}, ln, 1'b0));
                        x = x >> 8;
                    end
                    if (pending_words.size() > first) begin
                        o = pending_words[$];
                        o.last = 1'b1;
                        pending_words[pending_words.size() - 1] = o;
                    end
                    nx = ((x / f) << PBITS) + 64'(cumul_tab[w.symbol]) + (x % f);
                    lane_st[ln] = nx[31:0];
                    lane_cnt = lane_cnt + 5'd1;
                end
            end
            OP_FLUSH: begin
                for (int i = 0; i < NLANES; i++)
                    pending_words.push_back(mk_word(KIND_STATE, lane_st[i], 5'(i),
                                                    i == NLANES - 1));
                clear_lanes();
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(logic [1:0] op, logic [7:0] sym, logic [12:0] f, logic [11:0] c);
        in_word_t w;
        int gap;
        w.opcode = op;
        w.symbol = sym;
        w.freq_in = f;
        w.cumul_in = c;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        encode_model(w);
        words_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic load_sym(logic [7:0] sym, logic [12:0] f, logic [11:0] c);
        send_word(OP_LOAD, sym, f, c);
    endtask

    task automatic encode_sym(logic [7:0] sym);
        send_word(OP_ENCODE, sym, 13'($urandom), 12'($urandom));
    endtask

    task automatic flush_lanes();
        send_word(OP_FLUSH, 8'($urandom), 13'($urandom), 12'($urandom));
    endtask

    task automatic test_table_extremes();
        load_sym(8'd0, 13'd4096, 12'd0);
        load_sym(8'd255, 13'd1, 12'd4095);
        load_sym(8'd1, 13'd0, 12'd7);
        load_sym(8'd2, 13'd4096, 12'd4095);
        load_sym(8'd170, 13'd2, 12'd1);
        load_sym(8'd85, 13'd4095, 12'd2730);
    endtask

    task automatic test_directed_encode();
        encode_sym(8'd255);
        encode_sym(8'd0);
        encode_sym(8'd1);
        encode_sym(8'd2);
        encode_sym(8'd170);
        encode_sym(8'd85);
        encode_sym(8'd255);
        encode_sym(8'd255);
        send_word(OP_UNUSED, 8'hFF, 13'h1FFF, 12'hFFF);
        encode_sym(8'd1);
        flush_lanes();
        encode_sym(8'd170);
        flush_lanes();
    endtask

    task automatic random_stream(int count);
        int r;
        logic [12:0] f;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 12 || loaded_syms.size() == 0) begin
                case ($urandom_range(0, 5))
                    0: f = 13'd0;
                    1: f = 13'd4096;
                    2, 3: f = 13'($urandom_range(1, 16));
                    default: f = 13'($urandom_range(1, 4096));
                endcase
                load_sym(8'($urandom), f, 12'($urandom));
            end else if (r < 16) begin
                flush_lanes();
            end else if (r < 18) begin
                send_word(OP_UNUSED, 8'($urandom), 13'($urandom), 12'($urandom));
            end else begin
                encode_sym(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
            end
        end
    endtask

    task automatic test_random_first();
        random_stream(135);
    endtask

    task automatic test_drain_pause();
        wait_drained();
        random_stream(5);
    endtask

    task automatic test_random_second();
        random_stream(130);
        flush_lanes();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            case ((words_sent / 40) % 3)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 1);
                default: m_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        out_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: kind=%0d data=%h lane=%0d last=%0b",
                             m_data.kind, m_data.out_data, m_data.lane, m_data.last);
            end else begin
                e = pending_words.pop_front();
                case (m_data.kind)
                    KIND_BYTE: bytes_seen++;
                    KIND_STATE: states_seen++;
                    default: errors_seen++;
                endcase
                if (m_data.kind !== e.kind || m_data.out_data !== e.out_data ||
                    m_data.lane !== e.lane || m_data.last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected kind=%0d data=%h lane=%0d last=%0b, got kind=%0d data=%h lane=%0d last=%0b",
                                 e.kind, e.out_data, e.lane, e.last,
                                 m_data.kind, m_data.out_data, m_data.lane, m_data.last);
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < 256; i++) loaded[i] = 1'b0;
        clear_lanes();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_table_extremes();
        test_directed_encode();
        test_random_first();
        test_drain_pause();
        test_random_second();
        wait_drained();
        $display("Sent %0d words; checked %0d bytes, %0d state words and %0d errors.",
                 words_sent, bytes_seen, states_seen, errors_seen);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timed out with %0d results outstanding.", pending_words.size());
        $display("Regression FAIL");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/irans_pkg.sv
rtl/irans_div.sv
rtl/interleaved_rans_encoder.sv
tb/tb.sv
